/* rtl/cvl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cvl_pkg: shared types and codes for the compacting value list
// Command and result word layouts, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package cvl_pkg;

    // default number of list entries held in memory
    localparam int CAPACITY_DEF = 16;

    // fixed field widths
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;

    // capacity register reset value
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    // command word
    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] entry_value;
        logic [CNT_W-1:0]          entry_count;
        logic                      last;
    } result_t;

endpackage
`default_nettype wire

/* rtl/cvl_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cvl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/cvl_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cvl_ctrl: list sequencer
// Runs append, delete-with-compaction and dump against the entry memory,
// keeps the entry count and registers the result word.
// ----------------------------------------------------------------------------
module cvl_ctrl #(
    parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire cvl_pkg::cmd_t                    cmd,
    input  wire logic [cvl_pkg::CNT_W-1:0]        limit,
    output logic                                  strobe,
    output cvl_pkg::result_t                      result,
    output logic                                  mem_we,
    output logic [$clog2(CAPACITY)-1:0]           mem_waddr,
    output logic [cvl_pkg::VALUE_W-1:0]           mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]           mem_raddr,
    input  wire logic [cvl_pkg::VALUE_W-1:0]      mem_rdata
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = cvl_pkg::CNT_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DEL  = 2'd1;
    localparam logic [1:0] ST_DUMP = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            pos_reg, pos_next;
    logic [cvl_pkg::VALUE_W-1:0] val_reg, val_next;
    logic                        found_reg, found_next;
    logic                        strobe_reg, strobe_next;
    cvl_pkg::result_t            result_reg, result_next;

    logic                        accept;
    logic                        match;
    logic                        at_end;

    assign accept = start && (state_reg == ST_IDLE);
    assign match  = (mem_rdata == val_reg);
    assign at_end = (pos_reg == CNT_W'(count_reg - 1'b1));

    // next-state and memory access logic
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        found_next  = found_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_waddr   = ADDR_W'(count_reg);
        mem_wdata   = cmd.value;
        mem_raddr   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.func)
                        cvl_pkg::FUNC_APPEND:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg >= limit)
                            begin
                                result_next = '{cvl_pkg::STAT_FULL, cmd.value,
                                                count_reg, 1'b1};
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                count_next  = CNT_W'(count_reg + 1'b1);
                                result_next = '{cvl_pkg::STAT_OK, cmd.value,
                                                CNT_W'(count_reg + 1'b1), 1'b1};
                            end
                        end
                        cvl_pkg::FUNC_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                result_next = '{cvl_pkg::STAT_EMPTY, cmd.value,
                                                '0, 1'b1};
                            end
                            else
                            begin
                                pos_next   = '0;
                                found_next = 1'b0;
                                val_next   = cmd.value;
                                state_next = ST_DEL;
                            end
                        end
                        cvl_pkg::FUNC_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                result_next = '{cvl_pkg::STAT_EMPTY, '0, '0, 1'b1};
                            end
                            else
                            begin
                                pos_next   = '0;
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            // unused code: no effect
                        end
                    endcase
                end
            end

            // scan for first match, shifting later entries down one place
            ST_DEL:
            begin
                mem_raddr  = ADDR_W'(pos_reg + 1'b1);
                found_next = found_reg || match;
                pos_next   = CNT_W'(pos_reg + 1'b1);
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(pos_reg - 1'b1);
                    mem_wdata = mem_rdata;
                end
                if (at_end)
                begin
                    state_next  = ST_IDLE;
                    strobe_next = 1'b1;
                    if (found_reg || match)
                    begin
                        count_next  = CNT_W'(count_reg - 1'b1);
                        result_next = '{cvl_pkg::STAT_OK, val_reg,
                                        CNT_W'(count_reg - 1'b1), 1'b1};
                    end
                    else
                    begin
                        result_next = '{cvl_pkg::STAT_NOT_FOUND, val_reg,
                                        count_reg, 1'b1};
                    end
                end
            end

            // one entry word per cycle
            ST_DUMP:
            begin
                mem_raddr   = ADDR_W'(pos_reg + 1'b1);
                pos_next    = CNT_W'(pos_reg + 1'b1);
                strobe_next = 1'b1;
                result_next = '{cvl_pkg::STAT_OK, mem_rdata, count_reg, at_end};
                if (at_end)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        found_reg  <= found_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // count never passes the memory depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAPACITY)
        else $error("entry count beyond capacity");

    // a successful append grows the list by one
    a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.func == cvl_pkg::FUNC_APPEND && count_reg < limit)
        |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("append did not grow count");

    // a dump cycle always delivers a word
    a_dump_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |=> strobe_reg)
        else $error("dump cycle without result word");

    // the final word of an item leaves the sequencer idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last) |-> !busy)
        else $error("last word while still busy");

endmodule
`default_nettype wire

/* rtl/compacting_value_list_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_value_list_top: ordered list of signed 32-bit values
// Append, delete first match with compaction, and dump, over an entry memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Append, and delete
// or dump on an empty list, return one word and leave busy low. Delete and
// dump on a list of N entries both walk the entry memory one entry per cycle
// through its single read port, delete writing each later entry back one
// place down. A dump returns N words on consecutive cycles, the final one
// flagged last. Every result word shows on result for exactly one cycle with
// strobe high; the receiver cannot hold it off, so it must take every word as
// it comes. Unused operation code 3 is accepted and gives no word. Write the
// capacity register only while busy is low and no word is pending.
module compacting_value_list_top #(
    parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire cvl_pkg::cmd_t                 cmd,
    output logic                               strobe,
    output cvl_pkg::result_t                   result,
    input  wire logic                          cfg_we,
    input  wire logic [cvl_pkg::CNT_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = cvl_pkg::CNT_W;

    logic [CNT_W-1:0]            cap_reg;
    logic [CNT_W-1:0]            limit;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [cvl_pkg::VALUE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [cvl_pkg::VALUE_W-1:0] mem_rdata;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= cvl_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    // capacity saturates at the memory depth
    assign limit = (32'(cap_reg) > CAPACITY) ? CNT_W'(CAPACITY) : cap_reg;

    cvl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .limit     (limit),
        .strobe    (strobe),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    cvl_ram #(
        .WIDTH (cvl_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the compacting value list
// A short table of commands walks the list through its corner cases (empty
// list, signed extremes, duplicates, full and lowered capacity, unused code),
// then randomized phases with varying capacity and append bias drive the list
// between empty and full. Every result word is checked against a behavioral
// copy of the list kept in this bench or a typed-in answer from the table.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAPACITY = cvl_pkg::CAPACITY_DEF;
    localparam logic [cvl_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 285;
    localparam int QUIET_TAIL = 40;
    localparam int SETTLE_CYCLES = 20;

    typedef enum logic { ROW_CMD, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        cvl_pkg::cmd_t             c;
        logic [cvl_pkg::CNT_W-1:0] cap;
        bit                        typed;
        cvl_pkg::result_t          want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cvl_pkg::cmd_t cmd = '0;
    logic strobe;
    cvl_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [cvl_pkg::CNT_W-1:0] cfg_data = '0;

    // typed-in answer for the word currently offered
    bit typed_on = 1'b0;
    cvl_pkg::result_t typed_want = '0;

    // shadow copy of the list
    logic signed [cvl_pkg::VALUE_W-1:0] shadow_entries [CAPACITY];
    int shadow_len = 0;
    logic [cvl_pkg::CNT_W-1:0] shadow_cap = cvl_pkg::CAP_RESET;

    cvl_pkg::result_t expected_words [$];
    stim_row_t stim_table [$];

    int errors = 0;
    int words_checked = 0;
    int n_append = 0, n_full = 0, n_delete = 0, n_not_found = 0, n_empty_op = 0;
    int n_dump = 0, n_unused = 0, n_cap_writes = 0;

    compacting_value_list_top #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .strobe   (strobe),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic cvl_pkg::result_t make_word(logic [cvl_pkg::STAT_W-1:0] status,
                                                   logic signed [cvl_pkg::VALUE_W-1:0] v,
                                                   int cnt, logic lst);
        cvl_pkg::result_t w;
        w.status = status;
        w.entry_value = v;
        w.entry_count = cvl_pkg::CNT_W'(cnt);
        w.last = lst;
        return w;
    endfunction

    // apply one command to the shadow list and queue the words it yields
    function automatic void predict_list_op(cvl_pkg::cmd_t c);
        int lim;
        int hit;
        lim = (shadow_cap > CAPACITY) ? CAPACITY : int'(shadow_cap);
        case (c.func)
            cvl_pkg::FUNC_APPEND:
            begin
                n_append++;
                if (shadow_len >= lim)
                begin
                    n_full++;
                    expected_words.push_back(
                        make_word(cvl_pkg::STAT_FULL, c.value, shadow_len, 1'b1));
                end
                else
                begin
                    shadow_entries[shadow_len] = c.value;
                    shadow_len++;
                    expected_words.push_back(
                        make_word(cvl_pkg::STAT_OK, c.value, shadow_len, 1'b1));
                end
            end
            cvl_pkg::FUNC_DELETE:
            begin
                n_delete++;
                hit = -1;
                for (int i = 0; i < shadow_len; i++)
                    if (hit < 0 && shadow_entries[i] == c.value)
                        hit = i;
                if (shadow_len == 0)
                begin
                    n_empty_op++;
                    expected_words.push_back(
                        make_word(cvl_pkg::STAT_EMPTY, c.value, 0, 1'b1));
                end
                else if (hit < 0)
                begin
                    n_not_found++;
                    expected_words.push_back(
                        make_word(cvl_pkg::STAT_NOT_FOUND, c.value, shadow_len, 1'b1));
                end
                else
                begin
                    // close the gap behind the first match
                    for (int i = hit; i < shadow_len - 1; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_len--;
                    expected_words.push_back(
                        make_word(cvl_pkg::STAT_OK, c.value, shadow_len, 1'b1));
                end
            end
            cvl_pkg::FUNC_DUMP:
            begin
                n_dump++;
                if (shadow_len == 0)
                begin
                    n_empty_op++;
                    expected_words.push_back(make_word(cvl_pkg::STAT_EMPTY, '0, 0, 1'b1));
                end
                else
                    for (int i = 0; i < shadow_len; i++)
                        expected_words.push_back(make_word(cvl_pkg::STAT_OK,
                                                           shadow_entries[i], shadow_len,
                                                           i == shadow_len - 1));
            end
            default:
                n_unused++;
        endcase
    endfunction

    // track accepted commands and register writes, check every result word
    always @(posedge clk)
    begin
        cvl_pkg::result_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            shadow_cap = cvl_pkg::CAP_RESET;
        end
        else
        begin
            if (cfg_we)
                shadow_cap = cfg_data;
            if (start && !busy)
            begin
                predict_list_op(cmd);
                // a table row with a typed-in answer takes the predicted word's place
                if (typed_on)
                begin
                    void'(expected_words.pop_back());
                    expected_words.push_back(typed_want);
                end
            end
            if (strobe)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d value %0d count %0d",
                           result.status, result.entry_value, result.entry_count);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        errors++;
                    end
                    if (result.entry_value !== want.entry_value)
                    begin
                        $error("entry_value: expected %0d, actual %0d",
                               want.entry_value, result.entry_value);
                        errors++;
                    end
                    if (result.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, result.entry_count);
                        errors++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, result.last);
                        errors++;
                    end
                end
            end
        end
    end

    // offer one word and wait until it is taken
    task automatic send_word(cvl_pkg::cmd_t c, bit typed, cvl_pkg::result_t w);
        start <= 1'b1;
        cmd <= c;
        typed_on <= typed;
        typed_want <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // drop start and put junk on the command bus while waiting out the gap
    task automatic hold_off(int gap);
        start <= 1'b0;
        cmd <= {2'($urandom), $urandom};
        typed_on <= 1'b0;
        repeat (gap)
            @(posedge clk);
    endtask

    // let the list go quiet, then let trailing work finish
    task automatic drain();
        start <= 1'b0;
        typed_on <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [cvl_pkg::CNT_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        n_cap_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic stim_row_t cmd_row(logic [cvl_pkg::FUNC_W-1:0] f,
                                          logic signed [cvl_pkg::VALUE_W-1:0] v);
        stim_row_t r;
        r.kind = ROW_CMD;
        r.c.func = f;
        r.c.value = v;
        r.cap = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(logic [cvl_pkg::FUNC_W-1:0] f,
                                            logic signed [cvl_pkg::VALUE_W-1:0] v,
                                            logic [cvl_pkg::STAT_W-1:0] status, int cnt);
        stim_row_t r;
        r = cmd_row(f, v);
        r.typed = 1'b1;
        r.want = make_word(status, v, cnt, 1'b1);
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [cvl_pkg::CNT_W-1:0] v);
        stim_row_t r;
        r = cmd_row(cvl_pkg::FUNC_DUMP, '0);
        r.kind = ROW_CFG;
        r.cap = v;
        return r;
    endfunction

    // stimulus
    initial
    begin
        logic [cvl_pkg::CNT_W-1:0] fixed_caps [7];
        logic signed [cvl_pkg::VALUE_W-1:0] pool [16];
        int pool_n;
        int counted;
        int phase;
        int phase_len;
        int bias;
        int pick;
        bit idle_phase;
        cvl_pkg::cmd_t c;

        fixed_caps = '{5'd16, 5'd31, 5'd2, 5'd1, 5'd0, 5'd17, 5'd16};
        pool_n = 0;
        counted = 0;
        phase = 0;

        // directed table: empty list, extremes, duplicates, capacity corners
        stim_table.push_back(typed_row(cvl_pkg::FUNC_DUMP, 32'sd0, cvl_pkg::STAT_EMPTY, 0));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_DELETE, -32'sd7, cvl_pkg::STAT_EMPTY, 0));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_APPEND, 32'sh7FFFFFFF, cvl_pkg::STAT_OK, 1));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_APPEND, 32'sh80000000, cvl_pkg::STAT_OK, 2));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_APPEND, 32'sd0, cvl_pkg::STAT_OK, 3));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_APPEND, -32'sd1, cvl_pkg::STAT_OK, 4));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_APPEND, 32'sd0, cvl_pkg::STAT_OK, 5));
        stim_table.push_back(cmd_row(cvl_pkg::FUNC_DUMP, 32'sd0));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_DELETE, 32'sd0, cvl_pkg::STAT_OK, 4));
        stim_table.push_back(cmd_row(cvl_pkg::FUNC_DUMP, 32'sh12345678));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_DELETE, 32'sd12345,
                                       cvl_pkg::STAT_NOT_FOUND, 4));
        stim_table.push_back(cmd_row(FUNC_UNUSED, 32'sh5A5A5A5A));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_DELETE, 32'sh7FFFFFFF, cvl_pkg::STAT_OK, 3));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_DELETE, 32'sd0, cvl_pkg::STAT_OK, 2));
        stim_table.push_back(cmd_row(cvl_pkg::FUNC_DUMP, -32'sd1));
        stim_table.push_back(cfg_row(5'd2));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_APPEND, 32'sd1, cvl_pkg::STAT_FULL, 2));
        stim_table.push_back(cfg_row(5'd1));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_APPEND, 32'sd2, cvl_pkg::STAT_FULL, 2));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_DELETE, 32'sh80000000, cvl_pkg::STAT_OK, 1));
        stim_table.push_back(cmd_row(cvl_pkg::FUNC_DUMP, 32'sd0));
        stim_table.push_back(cfg_row(5'd0));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_APPEND, 32'sd3, cvl_pkg::STAT_FULL, 1));
        stim_table.push_back(cfg_row(5'd31));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_APPEND, 32'sd3, cvl_pkg::STAT_OK, 2));
        stim_table.push_back(cmd_row(cvl_pkg::FUNC_DUMP, 32'sd0));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_DELETE, -32'sd1, cvl_pkg::STAT_OK, 1));
        stim_table.push_back(typed_row(cvl_pkg::FUNC_DELETE, 32'sd3, cvl_pkg::STAT_OK, 0));

        // reset
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CFG)
                write_capacity(stim_table[i].cap);
            else
            begin
                send_word(stim_table[i].c, stim_table[i].typed, stim_table[i].want);
                if ($urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 12));
            end
        end

        // random phases, each under its own capacity and append bias
        while (counted < RANDOM_ITEMS)
        begin
            write_capacity((phase < 7) ? fixed_caps[phase]
                                       : cvl_pkg::CNT_W'($urandom_range(0, 31)));
            bias = $urandom_range(20, 85);
            idle_phase = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(25, 45);
            for (int k = 0; k < phase_len && counted < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 3)
                    c.func = FUNC_UNUSED;
                else if (pick < bias)
                    c.func = cvl_pkg::FUNC_APPEND;
                else if (pick < bias + (100 - bias) * 3 / 4)
                    c.func = cvl_pkg::FUNC_DELETE;
                else
                    c.func = cvl_pkg::FUNC_DUMP;

                // mostly values already stored, some small ones for duplicates
                pick = $urandom_range(0, 99);
                if (pick < 55 && pool_n > 0)
                    c.value = pool[$urandom_range(0, ((pool_n < 16) ? pool_n : 16) - 1)];
                else if (pick < 80)
                    c.value = $signed($urandom_range(0, 7)) - 3;
                else
                    c.value = $urandom;

                if (c.func == cvl_pkg::FUNC_APPEND)
                begin
                    pool[pool_n % 16] = c.value;
                    pool_n++;
                end

                send_word(c, 1'b0, '0);
                if (c.func != FUNC_UNUSED)
                    counted++;
                if (idle_phase && counted < RANDOM_ITEMS - QUIET_TAIL
                        && $urandom_range(0, 99) < 30)
                    hold_off($urandom_range(1, 12));
            end
            phase++;
        end

        drain();

        if (expected_words.size() != 0)
        begin
            $error("%0d result words never arrived", expected_words.size());
            errors++;
        end

        $display("run covered %0d appends (%0d full), %0d deletes (%0d not found), %0d dumps",
                 n_append, n_full, n_delete, n_not_found, n_dump);
        $display("%0d ops on an empty list, %0d unused codes, %0d capacity writes, %0d words checked",
                 n_empty_op, n_unused, n_cap_writes, words_checked);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cvl_pkg.sv
rtl/cvl_ram.sv
rtl/cvl_ctrl.sv
rtl/compacting_value_list_top.sv
tb/tb_top.sv
